/* hdl/keypoint_anchor_proposal_decoder_unit_assert.svh */
// ----------------------------------------------------------------------------
// Keypoint decoder assertion macros
// Concurrent assertion forms used by the decoder point unit.
// ----------------------------------------------------------------------------
`ifndef KEYPOINT_ANCHOR_PROPOSAL_DECODER_UNIT_ASSERT_SVH
`define KEYPOINT_ANCHOR_PROPOSAL_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define KAPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kapd: implication check failed");

// next-cycle implication
`define KAPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kapd: next-cycle check failed");

`endif

/* hdl/kapd_pkg.sv */
// ----------------------------------------------------------------------------
// Keypoint decoder package
// Shared types and fixed constants of the keypoint anchor proposal decoder.
// ----------------------------------------------------------------------------
package kapd_pkg;

   localparam int OFFSET_COUNT = 10;
   localparam int CONF_POS     = 10;
   localparam int COLOR_POS    = 11;
   localparam int POINT_COUNT  = 5;

   localparam int VALUE_W  = 16;
   localparam int CELL_W   = 7;
   localparam int LEVEL_W  = 2;
   localparam int ANCHOR_W = 14;
   localparam int INDEX_W  = 3;
   localparam int POINT_W  = 18;
   localparam int CSR_IDX_W = 4;

   // datapath widths of the point math
   localparam int SUM_W = 18;
   localparam int V_W   = SUM_W + 5;
   localparam int P_W   = V_W + VALUE_W + 1;

   localparam logic [LEVEL_W-1:0] LEVEL_8  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_16 = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_32 = 2'd2;

   localparam logic [INDEX_W-1:0] LAST_POINT = 3'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONF_THRESHOLD = 4'd0,
      CSR_INV_SCALE      = 4'd1,
      CSR_OFFSET_X       = 4'd2,
      CSR_OFFSET_Y       = 4'd3
   } csr_index_type;

   localparam logic [VALUE_W-1:0] RST_CONF_THRESHOLD = 16'd128;
   localparam logic [VALUE_W-1:0] RST_INV_SCALE      = 16'd4096;
   localparam logic [VALUE_W-1:0] RST_OFFSET         = 16'd0;

   typedef struct packed {
      logic [OFFSET_COUNT-1:0][VALUE_W-1:0] offsets;
      logic [CELL_W-1:0]                    cell_x;
      logic [CELL_W-1:0]                    cell_y;
      logic [LEVEL_W-1:0]                   level;
      logic                                 enemy_color;
      logic                                 blade_type;
      logic [VALUE_W-1:0]                   confidence;
      logic [ANCHOR_W-1:0]                  anchor;
   } proposal_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  index;
      logic                enemy_color;
      logic                blade_type;
      logic [VALUE_W-1:0]  confidence;
      logic [ANCHOR_W-1:0] anchor;
      logic                last;
   } point_meta_type;

endpackage

/* hdl/kapd_front.sv */
// ----------------------------------------------------------------------------
// Keypoint decoder front end
// Walks the row layout, tracks the anchor grid, buffers offsets, picks the
// best color and class, and queues a proposal for each passing row.
// ----------------------------------------------------------------------------
module kapd_front #(
   parameter int INPUT_SIZE  = 640,
   parameter int COLOR_COUNT = 2,
   parameter int CLASS_COUNT = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [kapd_pkg::VALUE_W-1:0]   req_raw_value,
   input  logic                           req_frame_start,
   output logic                           req_stall,
   input  logic [kapd_pkg::VALUE_W-1:0]   conf_threshold,
   input  logic                           q_full,
   output logic                           q_push,
   output kapd_pkg::proposal_type         q_rec
);
   import kapd_pkg::*;

   localparam int CLASS_POS = COLOR_POS + COLOR_COUNT;
   localparam int ROW_LEN   = CLASS_POS + CLASS_COUNT;
   localparam int POS_W     = $clog2(ROW_LEN);
   localparam int CIDX_W    = $clog2(COLOR_COUNT);
   localparam int KIDX_W    = $clog2(CLASS_COUNT);

   localparam logic [POS_W-1:0]  POS_LAST = POS_W'(ROW_LEN - 1);
   localparam logic [POS_W-1:0]  POS_CONF = POS_W'(CONF_POS);
   localparam logic [POS_W-1:0]  POS_COLOR = POS_W'(COLOR_POS);
   localparam logic [POS_W-1:0]  POS_CLASS = POS_W'(CLASS_POS);
   localparam logic [CELL_W-1:0] LAST8  = CELL_W'(INPUT_SIZE / 8 - 1);
   localparam logic [CELL_W-1:0] LAST16 = CELL_W'(INPUT_SIZE / 16 - 1);
   localparam logic [CELL_W-1:0] LAST32 = CELL_W'(INPUT_SIZE / 32 - 1);

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CELL_W-1:0]   col_ff, col_in;
   logic [CELL_W-1:0]   row_ff, row_in;
   logic [LEVEL_W-1:0]  lvl_ff, lvl_in;
   logic [ANCHOR_W-1:0] anchor_ff, anchor_in;
   logic [VALUE_W-1:0]  conf_ff, conf_in;
   logic [VALUE_W-1:0]  color_score_ff, color_score_in;
   logic [CIDX_W-1:0]   color_idx_ff, color_idx_in;
   logic [VALUE_W-1:0]  class_score_ff, class_score_in;
   logic [KIDX_W-1:0]   class_idx_ff, class_idx_in;
   logic [OFFSET_COUNT-1:0][VALUE_W-1:0] offsets_ff;

   logic                accept;
   logic [POS_W-1:0]    pos;
   logic [CELL_W-1:0]   col;
   logic [CELL_W-1:0]   row;
   logic [LEVEL_W-1:0]  lvl;
   logic [ANCHOR_W-1:0] anchor;
   logic [CELL_W-1:0]   grid_last;
   logic [POS_W-1:0]    color_off;
   logic [POS_W-1:0]    class_off;
   logic                row_done;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      pos    = req_frame_start ? '0 : pos_ff;
      col    = req_frame_start ? '0 : col_ff;
      row    = req_frame_start ? '0 : row_ff;
      lvl    = req_frame_start ? LEVEL_8 : lvl_ff;
      anchor = req_frame_start ? '0 : anchor_ff;

      color_off = pos - POS_COLOR;
      class_off = pos - POS_CLASS;
      row_done  = (pos == POS_LAST);

      case (lvl)
         LEVEL_8:  grid_last = LAST8;
         LEVEL_16: grid_last = LAST16;
         default:  grid_last = LAST32;
      endcase

      conf_in        = conf_ff;
      color_score_in = color_score_ff;
      color_idx_in   = color_idx_ff;
      class_score_in = class_score_ff;
      class_idx_in   = class_idx_ff;

      if (pos == POS_CONF) begin
         conf_in = req_raw_value;
      end else if (pos >= POS_COLOR && pos < POS_CLASS) begin
         if (color_off == '0 || $signed(req_raw_value) > $signed(color_score_ff)) begin
            color_score_in = req_raw_value;
            color_idx_in   = color_off[CIDX_W-1:0];
         end
      end else if (pos >= POS_CLASS) begin
         if (class_off == '0 || $signed(req_raw_value) > $signed(class_score_ff)) begin
            class_score_in = req_raw_value;
            class_idx_in   = class_off[KIDX_W-1:0];
         end
      end

      pos_in    = row_done ? '0 : pos + 1'b1;
      col_in    = col;
      row_in    = row;
      lvl_in    = lvl;
      anchor_in = anchor;
      if (row_done) begin
         anchor_in = anchor + 1'b1;
         col_in    = col + 1'b1;
         if (col == grid_last) begin
            col_in = '0;
            row_in = row + 1'b1;
            if (row == grid_last) begin
               row_in = '0;
               lvl_in = lvl + 1'b1;
               if (lvl == LEVEL_32) begin
                  lvl_in    = LEVEL_8;
                  anchor_in = '0;
               end
            end
         end
      end

      q_push              = accept && row_done && ($signed(conf_ff) >= $signed(conf_threshold));
      q_rec.offsets       = offsets_ff;
      q_rec.cell_x        = col;
      q_rec.cell_y        = row;
      q_rec.level         = lvl;
      q_rec.enemy_color   = (color_idx_ff != '0);
      q_rec.blade_type    = (class_idx_in != '0);
      q_rec.confidence    = conf_ff;
      q_rec.anchor        = anchor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         lvl_ff         <= LEVEL_8;
         anchor_ff      <= '0;
         conf_ff        <= '0;
         color_score_ff <= '0;
         color_idx_ff   <= '0;
         class_score_ff <= '0;
         class_idx_ff   <= '0;
      end else if (accept) begin
         pos_ff         <= pos_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         lvl_ff         <= lvl_in;
         anchor_ff      <= anchor_in;
         conf_ff        <= conf_in;
         color_score_ff <= color_score_in;
         color_idx_ff   <= color_idx_in;
         class_score_ff <= class_score_in;
         class_idx_ff   <= class_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pos < POS_CONF) begin
         offsets_ff[pos[3:0]] <= req_raw_value;
      end
   end

endmodule

/* hdl/kapd_queue.sv */
// ----------------------------------------------------------------------------
// Keypoint decoder proposal queue
// Short FIFO of row proposals between the front end and the point unit.
// ----------------------------------------------------------------------------
module kapd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  kapd_pkg::proposal_type push_rec,
   output logic                   full,
   input  logic                   pop,
   output logic                   pop_valid,
   output kapd_pkg::proposal_type pop_rec
);
   import kapd_pkg::*;

   proposal_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_rec   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

/* hdl/kapd_back.sv */
// ----------------------------------------------------------------------------
// Keypoint decoder point unit
// Expands each proposal into five points: cell add and stride shift,
// scale multiply, then round, pad subtract and saturate into the output.
// ----------------------------------------------------------------------------
`include "keypoint_anchor_proposal_decoder_unit_assert.svh"

module kapd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  kapd_pkg::proposal_type              q_rec,
   output logic                                q_pop,
   input  logic [kapd_pkg::VALUE_W-1:0]        inv_scale,
   input  logic [kapd_pkg::VALUE_W-1:0]        offset_x,
   input  logic [kapd_pkg::VALUE_W-1:0]        offset_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [kapd_pkg::INDEX_W-1:0]        rsp_point_index,
   output logic signed [kapd_pkg::POINT_W-1:0] rsp_point_x,
   output logic signed [kapd_pkg::POINT_W-1:0] rsp_point_y,
   output logic                                rsp_enemy_color,
   output logic                                rsp_blade_type,
   output logic signed [kapd_pkg::VALUE_W-1:0] rsp_confidence,
   output logic [kapd_pkg::ANCHOR_W-1:0]       rsp_anchor_number,
   output logic                                rsp_last_point
);
   import kapd_pkg::*;

   localparam int R_W = P_W + 1;
   localparam int Q_W = R_W - 16;
   localparam int D_W = Q_W + 1;
   localparam logic signed [R_W-1:0] ROUND_HALF = R_W'(32768);
   localparam logic signed [POINT_W-1:0] PT_MAX = {1'b0, {(POINT_W-1){1'b1}}};
   localparam logic signed [POINT_W-1:0] PT_MIN = {1'b1, {(POINT_W-1){1'b0}}};

   proposal_type        rec_ff;
   logic                busy_ff;
   logic [INDEX_W-1:0]  k_ff;

   logic                   s1_valid_ff;
   logic signed [V_W-1:0]  s1_vx_ff, s1_vy_ff;
   point_meta_type         s1_meta_ff;

   logic                   s2_valid_ff;
   logic signed [P_W-1:0]  s2_px_ff, s2_py_ff;
   point_meta_type         s2_meta_ff;

   logic                       out_valid_ff;
   logic signed [POINT_W-1:0]  out_x_ff, out_y_ff;
   point_meta_type             out_meta_ff;

   logic                   adv;
   logic                   emit;
   logic                   row_end;
   logic [VALUE_W-1:0]     off_x_raw, off_y_raw;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic signed [V_W-1:0]  ext_x, ext_y;
   logic signed [V_W-1:0]  v_x_in, v_y_in;
   point_meta_type         meta_in;
   logic signed [R_W-1:0]  r_x, r_y;
   logic signed [D_W-1:0]  d_x, d_y;
   logic signed [POINT_W-1:0] sat_x_in, sat_y_in;

   assign adv     = !(out_valid_ff && rsp_stall);
   assign emit    = busy_ff && adv;
   assign row_end = emit && (k_ff == LAST_POINT);
   assign q_pop   = q_valid && (!busy_ff || row_end);

   always_comb begin
      off_x_raw = rec_ff.offsets[{k_ff, 1'b0}];
      off_y_raw = rec_ff.offsets[{k_ff, 1'b1}];
      sum_x = $signed({{(SUM_W-VALUE_W){off_x_raw[VALUE_W-1]}}, off_x_raw})
            + $signed({{(SUM_W-CELL_W-8){1'b0}}, rec_ff.cell_x, 8'b0});
      sum_y = $signed({{(SUM_W-VALUE_W){off_y_raw[VALUE_W-1]}}, off_y_raw})
            + $signed({{(SUM_W-CELL_W-8){1'b0}}, rec_ff.cell_y, 8'b0});
      ext_x = {{(V_W-SUM_W){sum_x[SUM_W-1]}}, sum_x};
      ext_y = {{(V_W-SUM_W){sum_y[SUM_W-1]}}, sum_y};
      case (rec_ff.level)
         LEVEL_8: begin
            v_x_in = ext_x <<< 3;
            v_y_in = ext_y <<< 3;
         end
         LEVEL_16: begin
            v_x_in = ext_x <<< 4;
            v_y_in = ext_y <<< 4;
         end
         default: begin
            v_x_in = ext_x <<< 5;
            v_y_in = ext_y <<< 5;
         end
      endcase
      meta_in.index       = k_ff;
      meta_in.enemy_color = rec_ff.enemy_color;
      meta_in.blade_type  = rec_ff.blade_type;
      meta_in.confidence  = rec_ff.confidence;
      meta_in.anchor      = rec_ff.anchor;
      meta_in.last        = (k_ff == LAST_POINT);
   end

   // floor((p + 2^15) / 2^16) - pad, then clamp to the point range
   always_comb begin
      r_x = $signed({s2_px_ff[P_W-1], s2_px_ff}) + ROUND_HALF;
      r_y = $signed({s2_py_ff[P_W-1], s2_py_ff}) + ROUND_HALF;
      d_x = $signed({r_x[R_W-1], r_x[R_W-1:16]})
          - $signed({{(D_W-VALUE_W){offset_x[VALUE_W-1]}}, offset_x});
      d_y = $signed({r_y[R_W-1], r_y[R_W-1:16]})
          - $signed({{(D_W-VALUE_W){offset_y[VALUE_W-1]}}, offset_y});
      if (d_x[D_W-1:POINT_W-1] == '0 || d_x[D_W-1:POINT_W-1] == '1) begin
         sat_x_in = d_x[POINT_W-1:0];
      end else begin
         sat_x_in = d_x[D_W-1] ? PT_MIN : PT_MAX;
      end
      if (d_y[D_W-1:POINT_W-1] == '0 || d_y[D_W-1:POINT_W-1] == '1) begin
         sat_y_in = d_y[POINT_W-1:0];
      end else begin
         sat_y_in = d_y[D_W-1] ? PT_MIN : PT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         k_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            busy_ff <= 1'b1;
            k_ff    <= '0;
         end else if (row_end) begin
            busy_ff <= 1'b0;
            k_ff    <= '0;
         end else if (emit) begin
            k_ff <= k_ff + 1'b1;
         end
         if (adv) begin
            s1_valid_ff  <= busy_ff;
            s2_valid_ff  <= s1_valid_ff;
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rec_ff <= q_rec;
      end
      if (adv) begin
         s1_vx_ff    <= v_x_in;
         s1_vy_ff    <= v_y_in;
         s1_meta_ff  <= meta_in;
         s2_px_ff    <= s1_vx_ff * $signed({1'b0, inv_scale});
         s2_py_ff    <= s1_vy_ff * $signed({1'b0, inv_scale});
         s2_meta_ff  <= s1_meta_ff;
         out_x_ff    <= sat_x_in;
         out_y_ff    <= sat_y_in;
         out_meta_ff <= s2_meta_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_point_index   = out_meta_ff.index;
   assign rsp_point_x       = out_x_ff;
   assign rsp_point_y       = out_y_ff;
   assign rsp_enemy_color   = out_meta_ff.enemy_color;
   assign rsp_blade_type    = out_meta_ff.blade_type;
   assign rsp_confidence    = out_meta_ff.confidence;
   assign rsp_anchor_number = out_meta_ff.anchor;
   assign rsp_last_point    = out_meta_ff.last;

   `KAPD_ASSERT_IMPLY(a_pop_needs_data, clock, reset, q_pop, q_valid)
   `KAPD_ASSERT_IMPLY(a_point_in_range, clock, reset, out_valid_ff, out_meta_ff.index <= LAST_POINT)
   `KAPD_ASSERT_IMPLY(a_last_marks_fifth, clock, reset, out_valid_ff, out_meta_ff.last == (out_meta_ff.index == LAST_POINT))
   `KAPD_ASSERT_NEXT(a_idle_after_row, clock, reset, row_end && !q_valid, !busy_ff)

endmodule

/* hdl/keypoint_anchor_proposal_decoder_unit.sv */
// ----------------------------------------------------------------------------
// Keypoint anchor proposal decoder
// Streams detector rows, keeps passing anchors and emits five image-space
// keypoints per proposal.
//
//   channel  | handshake         | payload
//   ---------+-------------------+--------------------------------------------
//   req      | valid / stall     | raw_value, frame_start
//   rsp      | valid / stall     | point index, x, y, color, type, conf, anchor
//   csr      | valid / ready     | index, data (ready always high)
//
// One value is taken per cycle while req_stall is low; a passing row yields
// five points, one per cycle unless rsp is stalled, after its last value
// transfers. The two-entry proposal queue sets req_stall; the point unit
// emits five points per proposal, so rows of at least five values keep it
// clear unless rsp is stalled. Reset is synchronous; there is no clearing
// pass, the offset buffer is written before it is read.
// ----------------------------------------------------------------------------
module keypoint_anchor_proposal_decoder_unit #(
   parameter int INPUT_SIZE  = 640,
   parameter int COLOR_COUNT = 2,
   parameter int CLASS_COUNT = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [kapd_pkg::VALUE_W-1:0] req_raw_value,
   input  logic                                req_frame_start,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [kapd_pkg::INDEX_W-1:0]        rsp_point_index,
   output logic signed [kapd_pkg::POINT_W-1:0] rsp_point_x,
   output logic signed [kapd_pkg::POINT_W-1:0] rsp_point_y,
   output logic                                rsp_enemy_color,
   output logic                                rsp_blade_type,
   output logic signed [kapd_pkg::VALUE_W-1:0] rsp_confidence,
   output logic [kapd_pkg::ANCHOR_W-1:0]       rsp_anchor_number,
   output logic                                rsp_last_point,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kapd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kapd_pkg::VALUE_W-1:0]        csr_data
);
   import kapd_pkg::*;

   logic [VALUE_W-1:0] conf_threshold_ff;
   logic [VALUE_W-1:0] inv_scale_ff;
   logic [VALUE_W-1:0] offset_x_ff;
   logic [VALUE_W-1:0] offset_y_ff;

   logic         q_full;
   logic         q_push;
   proposal_type q_push_rec;
   logic         q_pop;
   logic         q_valid;
   proposal_type q_pop_rec;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_threshold_ff <= RST_CONF_THRESHOLD;
         inv_scale_ff      <= RST_INV_SCALE;
         offset_x_ff       <= RST_OFFSET;
         offset_y_ff       <= RST_OFFSET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CONF_THRESHOLD: conf_threshold_ff <= csr_data;
            CSR_INV_SCALE:      inv_scale_ff      <= csr_data;
            CSR_OFFSET_X:       offset_x_ff       <= csr_data;
            CSR_OFFSET_Y:       offset_y_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   kapd_front #(
      .INPUT_SIZE  (INPUT_SIZE),
      .COLOR_COUNT (COLOR_COUNT),
      .CLASS_COUNT (CLASS_COUNT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_raw_value   (req_raw_value),
      .req_frame_start (req_frame_start),
      .req_stall       (req_stall),
      .conf_threshold  (conf_threshold_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_rec           (q_push_rec)
   );

   kapd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_rec  (q_push_rec),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_rec   (q_pop_rec)
   );

   kapd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_rec             (q_pop_rec),
      .q_pop             (q_pop),
      .inv_scale         (inv_scale_ff),
      .offset_x          (offset_x_ff),
      .offset_y          (offset_y_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_point_index   (rsp_point_index),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_enemy_color   (rsp_enemy_color),
      .rsp_blade_type    (rsp_blade_type),
      .rsp_confidence    (rsp_confidence),
      .rsp_anchor_number (rsp_anchor_number),
      .rsp_last_point    (rsp_last_point)
   );

endmodule

/* tb/sv/keypoint_anchor_proposal_decoder_unit_tb.sv */
// ----------------------------------------------------------------------------
// Keypoint anchor proposal decoder testbench
// Streams detector rows into the decoder and predicts each image-space point
// in step with the input. Every point transfer is compared field by field.
// Coverage: frame restarts, score ties, threshold boundaries, saturation,
// register extremes, ignored register writes and a short run from a frame head.
// Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypoint_anchor_proposal_decoder_unit_tb;
   import kapd_pkg::*;

   localparam int INPUT_SIZE  = 640;
   localparam int COLOR_COUNT = 2;
   localparam int CLASS_COUNT = 2;
   localparam int CLASS_POS   = COLOR_POS + COLOR_COUNT;
   localparam int ROW_LEN     = CLASS_POS + CLASS_COUNT;

   localparam int SWEEP_ROWS   = 4;
   localparam int DRAIN_CYCLES = 16;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 16'sh8000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7FFF;
   localparam longint POINT_MAX = (64'sd1 <<< (POINT_W - 1)) - 1;
   localparam longint POINT_MIN = -(64'sd1 <<< (POINT_W - 1));

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURST} stall_mode_type;

   typedef struct {
      logic [INDEX_W-1:0]         point_index;
      logic signed [POINT_W-1:0]  point_x;
      logic signed [POINT_W-1:0]  point_y;
      logic                       enemy_color;
      logic                       blade_type;
      logic signed [VALUE_W-1:0]  confidence;
      logic [ANCHOR_W-1:0]        anchor_number;
      logic                       last_point;
   } keypoint_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [VALUE_W-1:0]   req_raw_value = '0;
   logic                        req_frame_start = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [INDEX_W-1:0]          rsp_point_index;
   logic signed [POINT_W-1:0]   rsp_point_x;
   logic signed [POINT_W-1:0]   rsp_point_y;
   logic                        rsp_enemy_color;
   logic                        rsp_blade_type;
   logic signed [VALUE_W-1:0]   rsp_confidence;
   logic [ANCHOR_W-1:0]         rsp_anchor_number;
   logic                        rsp_last_point;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [VALUE_W-1:0]          csr_data = '0;

   // decoder state as the predictor sees it
   logic signed [VALUE_W-1:0]   cfg_threshold = RST_CONF_THRESHOLD;
   logic [VALUE_W-1:0]          cfg_inv_scale = RST_INV_SCALE;
   logic signed [VALUE_W-1:0]   cfg_offset_x = RST_OFFSET;
   logic signed [VALUE_W-1:0]   cfg_offset_y = RST_OFFSET;
   logic signed [VALUE_W-1:0]   row_offsets [OFFSET_COUNT] = '{default: '0};
   logic signed [VALUE_W-1:0]   row_conf = '0;
   logic signed [VALUE_W-1:0]   best_color = '0;
   logic signed [VALUE_W-1:0]   best_class = '0;
   int                          color_winner = 0;
   int                          class_winner = 0;
   int                          element = 0;
   int                          cell_col = 0;
   int                          cell_row = 0;
   logic [LEVEL_W-1:0]          level = LEVEL_8;
   int                          anchor = 0;

   keypoint_type                pending_points [$];
   int                          error_count = 0;
   int                          burst_left = 0;
   stall_mode_type              stall_mode = STALL_NONE;
   int                          stall_left = 0;
   int                          stall_run = 0;

   keypoint_anchor_proposal_decoder_unit #(
      .INPUT_SIZE  (INPUT_SIZE),
      .COLOR_COUNT (COLOR_COUNT),
      .CLASS_COUNT (CLASS_COUNT)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_raw_value     (req_raw_value),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_point_index   (rsp_point_index),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_enemy_color   (rsp_enemy_color),
      .rsp_blade_type    (rsp_blade_type),
      .rsp_confidence    (rsp_confidence),
      .rsp_anchor_number (rsp_anchor_number),
      .rsp_last_point    (rsp_last_point),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #100_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic signed [POINT_W-1:0] map_axis(
      input logic signed [VALUE_W-1:0] raw, input int cell_idx, input int stride,
      input logic signed [VALUE_W-1:0] pad);
      longint scaled;
      longint q;
      scaled = (longint'(raw) + longint'(cell_idx) * 256) * stride * longint'(cfg_inv_scale);
      q = ((scaled + 32768) >>> 16) - longint'(pad);
      if (q > POINT_MAX) q = POINT_MAX;
      if (q < POINT_MIN) q = POINT_MIN;
      return q[POINT_W-1:0];
   endfunction

   task automatic decode_value(input logic signed [VALUE_W-1:0] raw, input logic frame_start);
      int pos;
      int stride;
      int grid;
      keypoint_type pt;
      if (frame_start) begin
         element = 0;
         cell_col = 0;
         cell_row = 0;
         level = LEVEL_8;
         anchor = 0;
      end
      pos = (element >= ROW_LEN) ? 0 : element;
      if (pos < OFFSET_COUNT) begin
         row_offsets[pos] = raw;
      end else if (pos == CONF_POS) begin
         row_conf = raw;
      end else if (pos < CLASS_POS) begin
         if (pos == COLOR_POS || raw > best_color) begin
            best_color = raw;
            color_winner = pos - COLOR_POS;
         end
      end else begin
         if (pos == CLASS_POS || raw > best_class) begin
            best_class = raw;
            class_winner = pos - CLASS_POS;
         end
      end
      if (pos == ROW_LEN - 1) begin
         stride = 8 << level;
         if (row_conf >= cfg_threshold) begin
            for (int k = 0; k < POINT_COUNT; k++) begin
               pt.point_index   = INDEX_W'(k);
               pt.point_x       = map_axis(row_offsets[2*k], cell_col, stride, cfg_offset_x);
               pt.point_y       = map_axis(row_offsets[2*k+1], cell_row, stride, cfg_offset_y);
               pt.enemy_color   = (color_winner != 0);
               pt.blade_type    = (class_winner != 0);
               pt.confidence    = row_conf;
               pt.anchor_number = ANCHOR_W'(anchor);
               pt.last_point    = (pt.point_index == LAST_POINT);
               pending_points.insert(pending_points.size(), pt);
            end
         end
         grid = INPUT_SIZE / stride;
         anchor++;
         cell_col++;
         if (cell_col >= grid) begin
            cell_col = 0;
            cell_row++;
            if (cell_row >= grid) begin
               cell_row = 0;
               if (level == LEVEL_32) begin
                  level = LEVEL_8;
                  anchor = 0;
               end else begin
                  level++;
               end
            end
         end
         element = 0;
      end else begin
         element = pos + 1;
      end
   endtask

   // ---------------------------------------------------------------- checking
   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      keypoint_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $error("point transfer with nothing pending: index %0d anchor %0d",
                   rsp_point_index, rsp_anchor_number);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            compare_field("point_index", want.point_index, rsp_point_index);
            compare_field("point_x", want.point_x, rsp_point_x);
            compare_field("point_y", want.point_y, rsp_point_y);
            compare_field("enemy_color", want.enemy_color, rsp_enemy_color);
            compare_field("blade_type", want.blade_type, rsp_blade_type);
            compare_field("confidence", want.confidence, rsp_confidence);
            compare_field("anchor_number", want.anchor_number, rsp_anchor_number);
            compare_field("last_point", want.last_point, rsp_last_point);
         end
      end
   end

   // receiver back-pressure, switching between quiet, random and burst modes
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(STALL_NONE, STALL_BURST));
         stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall = 1'b0;
         end
         STALL_RANDOM: begin
            rsp_stall = 1'($urandom_range(0, 1));
         end
         default: begin
            if (stall_run == 0) begin
               rsp_stall = ~rsp_stall;
               stall_run = $urandom_range(1, 12);
            end
            stall_run--;
         end
      endcase
   end

   // ---------------------------------------------------------------- drivers
   task automatic send_value(input logic signed [VALUE_W-1:0] raw, input logic frame_start);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid = 1'b1;
      req_raw_value = raw;
      req_frame_start = frame_start;
      do @(posedge clock); while (req_stall);
      decode_value(raw, frame_start);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      burst_left = 0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CONF_THRESHOLD: cfg_threshold = data;
         CSR_INV_SCALE:      cfg_inv_scale = data;
         CSR_OFFSET_X:       cfg_offset_x = data;
         CSR_OFFSET_Y:       cfg_offset_y = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [VALUE_W-1:0] thr, input logic [VALUE_W-1:0] inv,
                                 input logic [VALUE_W-1:0] pad_x, input logic [VALUE_W-1:0] pad_y);
      wait_drained();
      write_register(CSR_CONF_THRESHOLD, thr);
      write_register(CSR_INV_SCALE, inv);
      write_register(CSR_OFFSET_X, pad_x);
      write_register(CSR_OFFSET_Y, pad_y);
      csr_valid = 1'b0;
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_raw();
      case ($urandom_range(0, 7))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return VALUE_W'($urandom_range(0, 64) - 32);
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // narrow range half of the time so ties are common
   function automatic logic signed [VALUE_W-1:0] pick_score();
      if ($urandom_range(0, 1) == 0) return VALUE_W'($urandom_range(0, 4) - 2);
      return VALUE_W'($urandom);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_confidence();
      case ($urandom_range(0, 7))
         0, 1, 2: return cfg_threshold;
         3:       return (cfg_threshold == VALUE_MIN) ? VALUE_MIN
                                                      : VALUE_W'(cfg_threshold - 1);
         4:       return VALUE_MAX;
         5:       return VALUE_MIN;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // one row; with noise on, a frame start may land mid-row, and the row is
   // padded afterwards so later rows stay aligned
   task automatic send_row(input logic signed [VALUE_W-1:0] conf, input logic frame_head,
                           input logic noisy);
      int restart_at;
      logic signed [VALUE_W-1:0] value;
      restart_at = (noisy && $urandom_range(0, 9) == 0) ? $urandom_range(1, ROW_LEN - 1) : -1;
      for (int pos = 0; pos < ROW_LEN; pos++) begin
         if (pos < OFFSET_COUNT) value = pick_raw();
         else if (pos == CONF_POS) value = conf;
         else value = pick_score();
         send_value(value, (pos == 0 && frame_head) || pos == restart_at);
      end
      for (int pad = 0; pad < restart_at; pad++) send_value(pick_raw(), 1'b0);
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_frame_restart();
      for (int pos = 0; pos < 6; pos++)
         send_value(pos[0] ? VALUE_MIN : VALUE_MAX, pos == 0);
      // restart mid-row: this value becomes element 0 of anchor 0
      for (int pos = 0; pos < OFFSET_COUNT; pos++) begin
         if (pos < 4) send_value(pos[0] ^ pos[1] ? VALUE_MAX : VALUE_MIN, pos == 0);
         else send_value(VALUE_W'(pos - 7), 1'b0);
      end
      send_value(cfg_threshold, 1'b0);
      send_value(16'sd5, 1'b0);
      send_value(16'sd5, 1'b0);
      send_value(VALUE_MIN, 1'b0);
      send_value(VALUE_MAX, 1'b0);
   endtask

   task automatic test_random_rows();
      for (int row = 0; row < 8; row++) begin
         if (row == 4) wait_drained();
         send_row(pick_confidence(), row == 0, 1'b1);
      end
   endtask

   task automatic test_register_extremes();
      for (int setting = 0; setting < 4; setting++) begin
         case (setting)
            0: apply_settings(VALUE_MIN, 16'hFFFF, VALUE_MAX, VALUE_MIN);
            1: apply_settings(VALUE_MAX, 16'h0000, VALUE_MIN, VALUE_MAX);
            2: apply_settings(16'sd0, 16'hFFFF, 16'sd0, 16'sd0);
            default: apply_settings(VALUE_W'($urandom), VALUE_W'($urandom),
                                    VALUE_W'($urandom), VALUE_W'($urandom));
         endcase
         for (int row = 0; row < 4; row++)
            send_row(pick_confidence(), row == 0, 1'b1);
      end
   endtask

   task automatic test_spare_index();
      wait_drained();
      write_register(CSR_IDX_W'($urandom_range(int'(CSR_OFFSET_Y) + 1, (1 << CSR_IDX_W) - 1)),
                     VALUE_W'($urandom));
      csr_valid = 1'b0;
      for (int row = 0; row < 2; row++)
         send_row(pick_confidence(), 1'b0, 1'b0);
   endtask

   // frame head followed by a short run of anchors under random pads
   task automatic test_frame_sweep();
      logic keep;
      apply_settings(16'sd0, RST_INV_SCALE, VALUE_W'($urandom_range(0, 255)),
                     VALUE_W'($urandom_range(0, 255)));
      for (int row = 0; row < SWEEP_ROWS; row++) begin
         keep = (row != 1);
         send_row(keep ? VALUE_W'($urandom_range(0, 32767))
                       : VALUE_W'(-1 - $urandom_range(0, 32767)),
                  row == 0, 1'b0);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_frame_restart();
      test_random_rows();
      test_register_extremes();
      test_spare_index();
      test_frame_sweep();
      wait_drained();
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
